[rtl/core/waypoint_navigation_pid_assert.svh]
// Assertion macros used by the checker wnp_check
`ifndef WAYPOINT_NAVIGATION_PID_ASSERT_SVH
`define WAYPOINT_NAVIGATION_PID_ASSERT_SVH

// Check that a condition in the same cycle implies a consequence
`define WNP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define WNP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/wnp_pkg.sv]
package wnp_pkg;

	localparam int ANGLE_FRAC_BITS  = 13;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;

	// pi with 30 fraction bits, and pi rounded to the angle format
	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [35:0] RND_Q30 = 36'sd1 <<< (29 - ANGLE_FRAC_BITS);
	localparam logic signed [35:0] PI_QW = (PI_Q30 + RND_Q30) >>> (30 - ANGLE_FRAC_BITS);
	localparam logic signed [17:0] PI_Q = PI_QW[17:0];

	// Configuration register defaults
	localparam logic [15:0] KP_RST  = 16'd2000;
	localparam logic [15:0] KI_RST  = 16'd2000;
	localparam logic [15:0] KD_RST  = 16'd75;
	localparam logic [9:0]  LF_RST  = 10'd1023;
	localparam logic [9:0]  RF_RST  = 10'd1023;
	localparam logic [15:0] RAD_RST = 16'd3277;
	localparam logic [14:0] LIM_RST = 15'd4096;

	// Item kinds
	localparam logic [1:0] KIND_GO   = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;

	typedef enum logic [2:0] {
		CFG_PROP       = 3'd0,
		CFG_INTEG      = 3'd1,
		CFG_DERIV      = 3'd2,
		CFG_LEFT_FULL  = 3'd3,
		CFG_RIGHT_FULL = 3'd4,
		CFG_ARRIVE     = 3'd5,
		CFG_TURN       = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_TURN  = 2'd1,
		PH_PID   = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_LOAD, OP_SQX, OP_SQY, OP_SQR, OP_ROT,
		OP_DECIDE, OP_MP, OP_MI, OP_MD, OP_SUM, OP_APPLY
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SQX, S_SQY, S_SQR, S_ROT, S_DECIDE,
		S_MP, S_MI, S_MD, S_SUM, S_APPLY, S_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic go_next;
		logic pid_go;
	} stat_t;

	// atan(2^-i) with 30 fraction bits
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314856;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043836;
			5'd3:  v = 30'd133525158;
			5'd4:  v = 30'd67021686;
			5'd5:  v = 30'd33543515;
			5'd6:  v = 30'd16775850;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194282;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/wnp_ctrl.sv]
module wnp_ctrl import wnp_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	localparam int STEP_W = $clog2(CORDIC_STEPS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  stat_t             stat,
	output cmd_t              cmd,
	output logic [STEP_W-1:0] rot_step
);

	state_t            state_q, state_n;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	assign rot_step = step_q;
	assign m_tvalid = out_valid_q;

	// State, rotation counter and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_ROT) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_n      = state_q;
		cmd.op       = OP_IDLE;
		cmd.out_load = 1'b0;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_n = stat.go_next ? S_SQX : S_OUT;
				end
			end
			S_SQX: begin
				cmd.op  = OP_SQX;
				state_n = S_SQY;
			end
			S_SQY: begin
				cmd.op  = OP_SQY;
				state_n = S_SQR;
			end
			S_SQR: begin
				cmd.op  = OP_SQR;
				state_n = S_ROT;
			end
			S_ROT: begin
				cmd.op = OP_ROT;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_n = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_n = stat.pid_go ? S_MP : S_OUT;
			end
			S_MP: begin
				cmd.op  = OP_MP;
				state_n = S_MI;
			end
			S_MI: begin
				cmd.op  = OP_MI;
				state_n = S_MD;
			end
			S_MD: begin
				cmd.op  = OP_MD;
				state_n = S_SUM;
			end
			S_SUM: begin
				cmd.op  = OP_SUM;
				state_n = S_APPLY;
			end
			S_APPLY: begin
				cmd.op  = OP_APPLY;
				state_n = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

endmodule

[rtl/core/wnp_dpath.sv]
module wnp_dpath import wnp_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	localparam int STEP_W = $clog2(CORDIC_STEPS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [STEP_W-1:0]   rot_step,
	output stat_t               stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          kind,
	input  logic signed [23:0]  goal_x,
	input  logic signed [23:0]  goal_y,
	input  logic signed [23:0]  pos_x,
	input  logic signed [23:0]  pos_y,
	input  logic signed [15:0]  heading,
	input  logic                pid_tick,
	output logic [9:0]          left_drive,
	output logic [9:0]          right_drive,
	output logic                arrived,
	output logic [1:0]          phase
);

	localparam int RSH = 30 - ANGLE_FRAC_BITS;

	// Configuration
	logic [15:0] kp_q, ki_q, kd_q, rad_q;
	logic [9:0]  lf_q, rf_q;
	logic [14:0] lim_q;

	// Navigation state
	logic               going_q, restart_q, starting_q, arrived_q, tick_q, zero_q;
	phase_t             nav_q;
	logic signed [31:0] integ_q;
	logic signed [15:0] prev_q, e_q, hd_q;
	logic [9:0]         left_q, right_q;
	logic signed [23:0] tx_q, ty_q;

	// Arithmetic working registers
	logic signed [24:0] dx_q, dy_q;
	logic signed [33:0] x_q, y_q;
	logic signed [35:0] z_q;
	logic signed [49:0] prod_q, acc_q, f_q;
	logic [49:0]        d2_q;
	logic [31:0]        r2_q;

	// Output register
	logic [9:0] out_left_q, out_right_q;
	logic       out_arr_q;
	logic [1:0] out_ph_q;

	assign left_drive  = out_left_q;
	assign right_drive = out_right_q;
	assign arrived     = out_arr_q;
	assign phase       = out_ph_q;

	// Load-time selection
	logic               going_n;
	logic signed [23:0] tx_n, ty_n;
	always_comb begin
		going_n = going_q;
		tx_n    = tx_q;
		ty_n    = ty_q;
		if (kind == KIND_GO) begin
			going_n = 1'b1;
			tx_n    = goal_x;
			ty_n    = goal_y;
		end else if (kind == KIND_STOP) begin
			going_n = 1'b0;
		end
	end

	// Shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic signed [16:0] d_err;
	assign d_err = 17'(e_q) - 17'(prev_q);
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQX: begin
				mul_a = 34'(dx_q);
				mul_b = 34'(dx_q);
			end
			OP_SQY: begin
				mul_a = 34'(dy_q);
				mul_b = 34'(dy_q);
			end
			OP_MP: begin
				mul_a = $signed({18'd0, kp_q});
				mul_b = 34'(e_q);
			end
			OP_MI: begin
				mul_a = $signed({18'd0, ki_q});
				mul_b = 34'(integ_q);
			end
			OP_MD: begin
				mul_a = $signed({18'd0, kd_q});
				mul_b = 34'(d_err);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// CORDIC vectoring step
	logic signed [33:0] xs, ys;
	logic signed [35:0] atan_v;
	assign xs     = x_q >>> rot_step;
	assign ys     = y_q >>> rot_step;
	assign atan_v = $signed({6'd0, atan_q30(5'(rot_step))});

	// Bearing error, wrap and limits
	logic signed [35:0] brg_w;
	logic signed [17:0] e_raw, e_w, lim_s;
	logic               near, e_gt, e_lt;
	phase_t             ph;
	always_comb begin
		brg_w = zero_q ? 36'sd0 : ((z_q + RND_Q30) >>> RSH);
		e_raw = 18'(hd_q) - brg_w[17:0];
		if (e_raw > PI_Q) begin
			e_w = e_raw - (PI_Q <<< 1);
		end else if (e_raw < -PI_Q) begin
			e_w = e_raw + (PI_Q <<< 1);
		end else begin
			e_w = e_raw;
		end
		lim_s = $signed({3'd0, lim_q});
		e_gt  = e_w > lim_s;
		e_lt  = e_w < -lim_s;
		near  = d2_q <= {18'd0, r2_q};
		ph    = starting_q ? PH_START : nav_q;
	end

	assign stat.go_next = going_n;
	assign stat.pid_go  = (ph == PH_PID) && !near && !e_gt && !e_lt && tick_q;

	// Integral update with restart and saturation
	logic signed [15:0] pv;
	logic signed [33:0] isum;
	logic signed [31:0] isat;
	always_comb begin
		pv   = restart_q ? e_q : prev_q;
		isum = (restart_q ? 34'sd0 : 34'(integ_q)) + 34'(e_q) + 34'(pv);
		if (isum > 34'sd2147483647) begin
			isat = 32'sh7FFFFFFF;
		end else if (isum < -34'sd2147483648) begin
			isat = 32'sh80000000;
		end else begin
			isat = isum[31:0];
		end
	end

	// Steering correction: truncate f / (20 * 2^13) toward zero, saturate at 1024
	logic [49:0] fmag;
	logic [34:0] fsh;
	logic [29:0] q_prod;
	logic [10:0] q;
	always_comb begin
		fmag   = f_q[49] ? 50'(-f_q) : 50'(f_q);
		fsh    = fmag[49:15];
		q_prod = fsh[12:0] * 17'd52429;
		q      = (fsh > 35'd5119) ? 11'd1024 : q_prod[28:18];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= KP_RST;
			ki_q  <= KI_RST;
			kd_q  <= KD_RST;
			lf_q  <= LF_RST;
			rf_q  <= RF_RST;
			rad_q <= RAD_RST;
			lim_q <= LIM_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PROP:       kp_q  <= cfg_data;
				CFG_INTEG:      ki_q  <= cfg_data;
				CFG_DERIV:      kd_q  <= cfg_data;
				CFG_LEFT_FULL:  lf_q  <= cfg_data[9:0];
				CFG_RIGHT_FULL: rf_q  <= cfg_data[9:0];
				CFG_ARRIVE:     rad_q <= cfg_data;
				CFG_TURN:       lim_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Navigation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			going_q    <= 1'b0;
			nav_q      <= PH_START;
			restart_q  <= 1'b0;
			integ_q    <= '0;
			prev_q     <= '0;
			left_q     <= '0;
			right_q    <= '0;
			tx_q       <= '0;
			ty_q       <= '0;
			starting_q <= 1'b0;
			arrived_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					going_q    <= going_n;
					tx_q       <= tx_n;
					ty_q       <= ty_n;
					starting_q <= (kind == KIND_GO);
					arrived_q  <= 1'b0;
					if (!going_n) begin
						left_q  <= '0;
						right_q <= '0;
					end
				end
				OP_DECIDE: begin
					starting_q <= 1'b0;
					case (ph)
						PH_START: nav_q <= near ? PH_STOP : PH_TURN;
						PH_TURN: begin
							if (near) begin
								nav_q <= PH_STOP;
							end else if (e_gt) begin
								left_q  <= lf_q;
								right_q <= '0;
							end else if (e_lt) begin
								left_q  <= '0;
								right_q <= rf_q;
							end else begin
								nav_q     <= PH_PID;
								restart_q <= 1'b1;
							end
						end
						PH_PID: begin
							if (near) begin
								nav_q <= PH_STOP;
							end else if (e_gt || e_lt) begin
								nav_q <= PH_TURN;
							end
						end
						PH_STOP: begin
							left_q    <= '0;
							right_q   <= '0;
							arrived_q <= 1'b1;
							going_q   <= 1'b0;
						end
						default: nav_q <= ph;
					endcase
				end
				OP_MP: begin
					integ_q   <= isat;
					prev_q    <= pv;
					restart_q <= 1'b0;
				end
				OP_APPLY: begin
					prev_q <= e_q;
					if (!f_q[49]) begin
						left_q  <= lf_q;
						right_q <= ({1'b0, rf_q} > q) ? 10'({1'b0, rf_q} - q) : 10'd0;
					end else begin
						left_q  <= ({1'b0, lf_q} > q) ? 10'({1'b0, lf_q} - q) : 10'd0;
						right_q <= rf_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Arithmetic datapath
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				tick_q <= pid_tick;
				hd_q   <= heading;
				dx_q   <= 25'(tx_n) - 25'(pos_x);
				dy_q   <= 25'(ty_n) - 25'(pos_y);
			end
			OP_SQX: begin
				prod_q <= mul_p[49:0];
				zero_q <= (dx_q == '0) && (dy_q == '0);
				if (dx_q[24]) begin
					x_q <= (-34'(dx_q)) <<< 6;
					y_q <= (-34'(dy_q)) <<< 6;
					z_q <= dy_q[24] ? -PI_Q30 : PI_Q30;
				end else begin
					x_q <= 34'(dx_q) <<< 6;
					y_q <= 34'(dy_q) <<< 6;
					z_q <= '0;
				end
			end
			OP_SQY: begin
				d2_q   <= 50'(prod_q);
				prod_q <= mul_p[49:0];
			end
			OP_SQR: begin
				d2_q <= d2_q + 50'(prod_q);
				r2_q <= rad_q * rad_q;
			end
			OP_ROT: begin
				if (!y_q[33]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end
			end
			OP_DECIDE: e_q <= e_w[15:0];
			OP_MP: prod_q <= mul_p[49:0];
			OP_MI: begin
				acc_q  <= (prod_q <<< 4) + (prod_q <<< 2);
				prod_q <= mul_p[49:0];
			end
			OP_MD: begin
				acc_q  <= acc_q + prod_q;
				prod_q <= mul_p[49:0];
			end
			OP_SUM: f_q <= acc_q + (prod_q <<< 7) + (prod_q <<< 6) + (prod_q <<< 3);
			default: ;
		endcase
		if (cmd.out_load) begin
			out_left_q  <= left_q;
			out_right_q <= right_q;
			out_arr_q   <= arrived_q;
			out_ph_q    <= nav_q;
		end
	end

endmodule

[rtl/core/waypoint_navigation_pid.sv]
// Channel  | Dir | Handshake         | Payload
// s        | in  | s_tvalid/s_tready | tuser: kind; tdata: goal, pose, heading, pid_tick
// m        | out | m_tvalid/m_tready | tdata: left_drive, right_drive, arrived, phase
// cfg      | in  | cfg_we            | cfg_index, cfg_data
//
// One item at a time: an item while not going, or a stop, goes straight to the output
// register; while going, the squares, the CORDIC rotation loop and the decision run,
// then the PID products, sum and apply when the PID runs, on the shared multiplier.
// A new item is taken while the previous beat waits at the output.
// arst_n clears the sequencer and navigation state and loads the configuration defaults.
module waypoint_navigation_pid import wnp_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // goal_x, goal_y, pos_x, pos_y, heading, pid_tick, pad
	input  logic [1:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,  // left_drive, right_drive, arrived, phase, pad
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);

	cmd_t              cmd;
	stat_t             stat;
	logic [STEP_W-1:0] rot_step;
	logic [9:0]        left_drive, right_drive;
	logic              arrived;
	logic [1:0]        phase;

	wnp_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd),
		.rot_step (rot_step)
	);

	wnp_dpath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rot_step    (rot_step),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (s_tuser),
		.goal_x      (s_tdata[23:0]),
		.goal_y      (s_tdata[47:24]),
		.pos_x       (s_tdata[71:48]),
		.pos_y       (s_tdata[95:72]),
		.heading     (s_tdata[111:96]),
		.pid_tick    (s_tdata[112]),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.arrived     (arrived),
		.phase       (phase)
	);

	assign m_tdata = {1'b0, phase, arrived, right_drive, left_drive};

endmodule

[rtl/core/wnp_check.sv]
`include "waypoint_navigation_pid_assert.svh"

module wnp_check import wnp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// Hold a stalled output beat
	`WNP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

	// Arrival reports the stop phase with both wheels off
	`WNP_ASSERT_SAME(a_arr_phase, m_tvalid && m_tdata[20], m_tdata[22:21] == PH_STOP, "arrival outside stop phase")
	`WNP_ASSERT_SAME(a_arr_drive, m_tvalid && m_tdata[20], m_tdata[19:0] == 20'd0, "wheels driven on arrival")

	// Work on one item at a time
	`WNP_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "input taken while busy")

endmodule

bind waypoint_navigation_pid wnp_check u_wnp_check (.*);
